// File: src/vpwb_pkg.sv
`timescale 1ns / 1ps
package vpwb_pkg;

    // op codes of an input item
    localparam logic [2:0] OP_ACCEL    = 3'd0;
    localparam logic [2:0] OP_FORCE    = 3'd1;
    localparam logic [2:0] OP_IMPULSE  = 3'd2;
    localparam logic [2:0] OP_RST_F    = 3'd3;
    localparam logic [2:0] OP_SIMULATE = 3'd4;
    localparam logic [2:0] OP_RESTRAIN = 3'd5;
    localparam logic [2:0] OP_PLACE    = 3'd6;

    // register indexes on the config port
    localparam logic [2:0] REG_MASS     = 3'd0;
    localparam logic [2:0] REG_BOUNCE   = 3'd1;
    localparam logic [2:0] REG_FRICTION = 3'd2;
    localparam logic [2:0] REG_TSTEP    = 3'd3;
    localparam logic [2:0] REG_WIDTH    = 3'd4;
    localparam logic [2:0] REG_HEIGHT   = 3'd5;

    // datapath actions
    localparam logic [4:0] A_NONE    = 5'd0;
    localparam logic [4:0] A_ACCEL   = 5'd1;
    localparam logic [4:0] A_RST_F   = 5'd2;
    localparam logic [4:0] A_PLACE   = 5'd3;
    localparam logic [4:0] A_FORCE_X = 5'd4;
    localparam logic [4:0] A_FORCE_Y = 5'd5;
    localparam logic [4:0] A_IMP_X   = 5'd6;
    localparam logic [4:0] A_IMP_Y   = 5'd7;
    localparam logic [4:0] A_MUL_TT  = 5'd8;
    localparam logic [4:0] A_DT2     = 5'd9;
    localparam logic [4:0] A_MUL_AX  = 5'd10;
    localparam logic [4:0] A_SIM_X   = 5'd11;
    localparam logic [4:0] A_SIM_Y   = 5'd12;
    localparam logic [4:0] A_RX0     = 5'd13;
    localparam logic [4:0] A_RX1     = 5'd14;
    localparam logic [4:0] A_RX2     = 5'd15;
    localparam logic [4:0] A_RX3     = 5'd16;
    localparam logic [4:0] A_RY0     = 5'd17;
    localparam logic [4:0] A_RY1     = 5'd18;
    localparam logic [4:0] A_RY2     = 5'd19;
    localparam logic [4:0] A_RY3     = 5'd20;
    localparam logic [4:0] A_CLAMP   = 5'd21;

    typedef struct packed {
        logic [2:0]         op;
        logic signed [31:0] vec_x;
        logic signed [31:0] vec_y;
    } t_in;

    typedef struct packed {
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
    } t_out;

    typedef struct packed {
        logic [30:0] mass;
        logic [16:0] bounce;
        logic [16:0] friction;
        logic [16:0] time_step;
        logic [30:0] world_width;
        logic [30:0] world_height;
    } t_cfg;

    typedef struct packed {
        logic [4:0] act;
        logic       vec_load;
        logic       div_start;
        logic       div_sel_y;
        logic       res_load;
    } t_cmd;

    typedef struct packed {
        logic div_done;
        logic x_hit;
        logic y_hit;
        logic mass_zero;
    } t_sts;

    function automatic logic signed [31:0] sat32(input logic signed [55:0] v);
        if (v > 56'sd2147483647) begin
            return 32'sh7fffffff;
        end else if (v < -56'sd2147483648) begin
            return 32'sh80000000;
        end
        return signed'(v[31:0]);
    endfunction

    // amount taken off the other axis at a wall
    function automatic logic signed [55:0] tangent(input logic signed [55:0] j,
                                                   input logic signed [55:0] k);
        logic signed [55:0] aj;
        logic signed [55:0] ak;
        aj = (j < 0) ? -j : j;
        ak = (k < 0) ? -k : k;
        if (j == 0) begin
            return '0;
        end else if (aj <= ak) begin
            return j + j;
        end else if ((j > 0 && k > 0) || (j < 0 && k < 0)) begin
            return k;
        end
        return '0;
    endfunction

endpackage

// File: src/vpwb_div.sv
`timescale 1ns / 1ps
module vpwb_div
    import vpwb_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic signed [31:0] i_value,
    input  logic [30:0]        i_mass,
    output logic               o_done,
    output logic signed [48:0] o_quo
);

    logic        r_busy;
    logic        r_done;
    logic        r_neg;
    logic [5:0]  r_cnt;
    logic [47:0] r_num;
    logic [31:0] r_rem;
    logic [31:0] mag;
    logic [31:0] rem_sh;
    logic [32:0] trial;

    // magnitude of the dividend, restoring step on one bit a cycle
    assign mag    = i_value[31] ? 32'(-33'(i_value)) : 32'(i_value);
    assign rem_sh = {r_rem[30:0], r_num[47]};
    assign trial  = {1'b0, rem_sh} - {2'b0, i_mass};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
        end else if (r_busy && r_cnt == '0) begin
            r_busy <= 1'b0;
            r_done <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_num <= {mag, 16'd0};
            r_rem <= '0;
            r_neg <= i_value[31];
            r_cnt <= 6'd47;
        end else if (r_busy) begin
            r_rem <= trial[32] ? rem_sh : trial[31:0];
            r_num <= {r_num[46:0], ~trial[32]};
            r_cnt <= r_cnt - 6'd1;
        end
    end

    // quotient truncated toward zero
    assign o_quo  = r_neg ? -signed'({1'b0, r_num}) : signed'({1'b0, r_num});
    assign o_done = r_done;

endmodule

// File: src/vpwb_datapath.sv
`timescale 1ns / 1ps
module vpwb_datapath
    import vpwb_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  t_cfg i_cfg,
    input  t_in  i_item,
    input  t_cmd i_cmd,
    output t_sts o_sts,
    output t_out o_res
);

    logic signed [31:0] r_px, r_py, r_qx, r_qy, r_ax, r_ay;
    logic signed [31:0] r_vx, r_vy, r_tx;
    logic signed [32:0] r_dx, r_dy;
    logic signed [52:0] r_prod;
    logic [17:0]        r_dt2;
    t_out               r_res;

    logic signed [33:0] mul_a;
    logic signed [18:0] mul_b;
    logic               mul_en;
    logic signed [52:0] mul_p;
    logic signed [36:0] prod_q;
    logic signed [55:0] w56, h56;
    logic signed [55:0] nx;
    logic               div_done;
    logic signed [48:0] quo;

    // shared divider for force and impulse
    vpwb_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.div_start),
        .i_value (i_cmd.div_sel_y ? r_vy : r_vx),
        .i_mass  (i_cfg.mass),
        .o_done  (div_done),
        .o_quo   (quo)
    );

    assign w56    = 56'(i_cfg.world_width);
    assign h56    = 56'(i_cfg.world_height);
    assign prod_q = signed'(r_prod[52:16]);
    assign nx     = 56'(r_px) + 56'(r_px) - 56'(r_qx) + 56'(prod_q);

    // shared multiplier operand selection
    always_comb begin
        mul_a  = '0;
        mul_b  = '0;
        mul_en = 1'b1;
        unique case (i_cmd.act)
            A_MUL_TT: begin
                mul_a = 34'(i_cfg.time_step);
                mul_b = 19'(i_cfg.time_step);
            end
            A_MUL_AX: begin
                mul_a = 34'(r_ax);
                mul_b = 19'(r_dt2);
            end
            A_SIM_X: begin
                mul_a = 34'(r_ay);
                mul_b = 19'(r_dt2);
            end
            A_RX1: begin
                mul_a = 34'(r_dx);
                mul_b = 19'(i_cfg.bounce);
            end
            A_RX2: begin
                mul_a = 34'(r_dx);
                mul_b = 19'(i_cfg.friction);
            end
            A_RY1: begin
                mul_a = 34'(r_dy);
                mul_b = 19'(i_cfg.bounce);
            end
            A_RY2: begin
                mul_a = 34'(r_dy);
                mul_b = 19'(i_cfg.friction);
            end
            default: mul_en = 1'b0;
        endcase
    end

    assign mul_p = mul_a * mul_b;

    // multiplier output register
    always_ff @(posedge i_clk) begin
        if (mul_en) begin
            r_prod <= mul_p;
        end
    end

    // input item capture and result register
    always_ff @(posedge i_clk) begin
        if (i_cmd.vec_load) begin
            r_vx <= i_item.vec_x;
            r_vy <= i_item.vec_y;
        end
        if (i_cmd.res_load) begin
            r_res.pos_x <= r_px;
            r_res.pos_y <= r_py;
        end
    end

    // particle state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_px <= '0;
            r_py <= '0;
            r_qx <= '0;
            r_qy <= '0;
            r_ax <= '0;
            r_ay <= '0;
        end else begin
            unique case (i_cmd.act)
                A_ACCEL: begin
                    r_ax <= sat32(56'(r_ax) + 56'(r_vx));
                    r_ay <= sat32(56'(r_ay) + 56'(r_vy));
                end
                A_RST_F: begin
                    r_ax <= '0;
                    r_ay <= '0;
                end
                A_PLACE: begin
                    r_px <= r_vx;
                    r_qx <= r_vx;
                    r_py <= r_vy;
                    r_qy <= r_vy;
                end
                A_FORCE_X: r_ax <= sat32(56'(r_ax) + 56'(quo));
                A_FORCE_Y: r_ay <= sat32(56'(r_ay) + 56'(quo));
                A_IMP_X:   r_px <= sat32(56'(r_px) + 56'(quo));
                A_IMP_Y:   r_py <= sat32(56'(r_py) + 56'(quo));
                A_DT2:     r_dt2 <= r_prod[33:16];
                A_SIM_X:   r_tx <= sat32(nx);
                A_SIM_Y: begin
                    r_qx <= r_px;
                    r_qy <= r_py;
                    r_px <= r_tx;
                    r_py <= sat32(56'(r_py) + 56'(r_py) - 56'(r_qy) + 56'(prod_q));
                    r_ax <= '0;
                    r_ay <= '0;
                end
                A_RX0: begin
                    if (o_sts.x_hit) begin
                        r_dx <= 33'(r_px) - 33'(r_qx);
                        r_dy <= 33'(r_py) - 33'(r_qy);
                        r_px <= r_px[31] ? sat32(-56'(r_px))
                                         : sat32(w56 + w56 - 56'(r_px));
                    end
                end
                A_RX2: r_qx <= sat32(56'(r_px) + 56'(prod_q));
                A_RX3: r_py <= sat32(56'(r_py) - tangent(56'(r_dy), 56'(prod_q)));
                A_RY0: begin
                    if (o_sts.y_hit) begin
                        r_dx <= 33'(r_px) - 33'(r_qx);
                        r_dy <= 33'(r_py) - 33'(r_qy);
                        r_py <= r_py[31] ? sat32(-56'(r_py))
                                         : sat32(h56 + h56 - 56'(r_py));
                    end
                end
                A_RY2: r_qy <= sat32(56'(r_py) + 56'(prod_q));
                A_RY3: r_px <= sat32(56'(r_px) - tangent(56'(r_dx), 56'(prod_q)));
                A_CLAMP: begin
                    if (r_px[31]) begin
                        r_px <= '0;
                    end else if (56'(r_px) > w56) begin
                        r_px <= signed'({1'b0, i_cfg.world_width});
                    end
                    if (r_py[31]) begin
                        r_py <= '0;
                    end else if (56'(r_py) > h56) begin
                        r_py <= signed'({1'b0, i_cfg.world_height});
                    end
                end
                default: ;
            endcase
        end
    end

    // status back to the controller
    assign o_sts.div_done  = div_done;
    assign o_sts.x_hit     = r_px[31] || (56'(r_px) > w56);
    assign o_sts.y_hit     = r_py[31] || (56'(r_py) > h56);
    assign o_sts.mass_zero = (i_cfg.mass == '0);
    assign o_res           = r_res;

endmodule

// File: src/vpwb_ctrl.sv
`timescale 1ns / 1ps
module vpwb_ctrl
    import vpwb_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  logic [2:0] i_op,
    input  logic       i_out_stall,
    input  t_sts       i_sts,
    output logic       o_in_stall,
    output logic       o_out_valid,
    output t_cmd       o_cmd
);

    localparam logic [4:0] ST_IDLE  = 5'd0;
    localparam logic [4:0] ST_EXEC  = 5'd1;
    localparam logic [4:0] ST_DXGO  = 5'd2;
    localparam logic [4:0] ST_DXW   = 5'd3;
    localparam logic [4:0] ST_DYGO  = 5'd4;
    localparam logic [4:0] ST_DYW   = 5'd5;
    localparam logic [4:0] ST_SIM0  = 5'd6;
    localparam logic [4:0] ST_SIM1  = 5'd7;
    localparam logic [4:0] ST_SIM2  = 5'd8;
    localparam logic [4:0] ST_SIM3  = 5'd9;
    localparam logic [4:0] ST_SIM4  = 5'd10;
    localparam logic [4:0] ST_RX0   = 5'd11;
    localparam logic [4:0] ST_RX1   = 5'd12;
    localparam logic [4:0] ST_RX2   = 5'd13;
    localparam logic [4:0] ST_RX3   = 5'd14;
    localparam logic [4:0] ST_RY0   = 5'd15;
    localparam logic [4:0] ST_RY1   = 5'd16;
    localparam logic [4:0] ST_RY2   = 5'd17;
    localparam logic [4:0] ST_RY3   = 5'd18;
    localparam logic [4:0] ST_CLAMP = 5'd19;
    localparam logic [4:0] ST_DONE  = 5'd20;

    logic [4:0] r_state, n_state;
    logic [2:0] r_op;
    logic       r_ovalid, n_ovalid;
    logic       accept;

    assign o_in_stall = (r_state != ST_IDLE);
    assign accept     = i_in_valid && !o_in_stall;

    // sequencing of the datapath
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    o_cmd.vec_load = 1'b1;
                    n_state        = ST_EXEC;
                end
            end
            ST_EXEC: begin
                if (r_op == OP_ACCEL) begin
                    o_cmd.act = A_ACCEL;
                end else if (r_op == OP_RST_F) begin
                    o_cmd.act = A_RST_F;
                end else if (r_op == OP_PLACE) begin
                    o_cmd.act = A_PLACE;
                end
                if (r_op == OP_FORCE || r_op == OP_IMPULSE) begin
                    n_state = i_sts.mass_zero ? ST_DONE : ST_DXGO;
                end else if (r_op == OP_SIMULATE) begin
                    n_state = i_sts.mass_zero ? ST_DONE : ST_SIM0;
                end else if (r_op == OP_RESTRAIN) begin
                    n_state = ST_RX0;
                end else begin
                    n_state = ST_DONE;
                end
            end
            ST_DXGO: begin
                o_cmd.div_start = 1'b1;
                n_state         = ST_DXW;
            end
            ST_DXW: begin
                if (i_sts.div_done) begin
                    o_cmd.act = (r_op == OP_FORCE) ? A_FORCE_X : A_IMP_X;
                    n_state   = ST_DYGO;
                end
            end
            ST_DYGO: begin
                o_cmd.div_start = 1'b1;
                o_cmd.div_sel_y = 1'b1;
                n_state         = ST_DYW;
            end
            ST_DYW: begin
                if (i_sts.div_done) begin
                    o_cmd.act = (r_op == OP_FORCE) ? A_FORCE_Y : A_IMP_Y;
                    n_state   = ST_DONE;
                end
            end
            ST_SIM0: begin
                o_cmd.act = A_MUL_TT;
                n_state   = ST_SIM1;
            end
            ST_SIM1: begin
                o_cmd.act = A_DT2;
                n_state   = ST_SIM2;
            end
            ST_SIM2: begin
                o_cmd.act = A_MUL_AX;
                n_state   = ST_SIM3;
            end
            ST_SIM3: begin
                o_cmd.act = A_SIM_X;
                n_state   = ST_SIM4;
            end
            ST_SIM4: begin
                o_cmd.act = A_SIM_Y;
                n_state   = ST_DONE;
            end
            ST_RX0: begin
                o_cmd.act = A_RX0;
                n_state   = i_sts.x_hit ? ST_RX1 : ST_RY0;
            end
            ST_RX1: begin
                o_cmd.act = A_RX1;
                n_state   = ST_RX2;
            end
            ST_RX2: begin
                o_cmd.act = A_RX2;
                n_state   = ST_RX3;
            end
            ST_RX3: begin
                o_cmd.act = A_RX3;
                n_state   = ST_RY0;
            end
            ST_RY0: begin
                o_cmd.act = A_RY0;
                n_state   = i_sts.y_hit ? ST_RY1 : ST_CLAMP;
            end
            ST_RY1: begin
                o_cmd.act = A_RY1;
                n_state   = ST_RY2;
            end
            ST_RY2: begin
                o_cmd.act = A_RY2;
                n_state   = ST_RY3;
            end
            ST_RY3: begin
                o_cmd.act = A_RY3;
                n_state   = ST_CLAMP;
            end
            ST_CLAMP: begin
                o_cmd.act = A_CLAMP;
                n_state   = ST_DONE;
            end
            ST_DONE: begin
                if (!r_ovalid || !i_out_stall) begin
                    o_cmd.res_load = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // result valid flag
    always_comb begin
        n_ovalid = r_ovalid;
        if (o_cmd.res_load) begin
            n_ovalid = 1'b1;
        end else if (!i_out_stall) begin
            n_ovalid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_ovalid <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_op <= i_op;
        end
    end

    assign o_out_valid = r_ovalid;

    a_accept_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> r_state == ST_EXEC)
        else $error("accepted item did not start");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ovalid && i_out_stall) |-> !o_cmd.res_load)
        else $error("pending result overwritten");

    a_div_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.div_start |=> !i_sts.div_done)
        else $error("divider done right after start");

    a_load_to_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.res_load |=> (r_state == ST_IDLE && r_ovalid))
        else $error("result load did not complete item");

endmodule

// File: src/verlet_particle_with_wall_bounce.sv
`timescale 1ns / 1ps
// Verlet particle in a walled box, Q16.16 fixed point.
// Input channel: i_valid / o_stall carry an item {op, vec_x, vec_y}.
// Output channel: o_valid / i_stall carry one item {pos_x, pos_y} per input item.
// Config: APB-style registers at byte address 4*i: mass, bounce, friction,
// time_step, world_width, world_height; the user must write them only while the
// block is idle, which the block itself does not enforce. Items are handled one
// at a time; o_stall is high from acceptance until the result has been moved
// into the output register. Accelerate, reset forces and place act in the
// execute state; simulate uses one shared multiplier in three passes;
// restrain runs the wall steps only for the walls hit; force and impulse run
// the shared 48-step one-bit-a-cycle divider once per axis. With zero mass,
// force, impulse and simulate go straight to done and change no state.
// A finished item waits in the output register while i_stall is high; the next
// item may be accepted meanwhile, and its result waits until the register frees.
// Reset clears the particle state and loads the register defaults.
module verlet_particle_with_wall_bounce
    import vpwb_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    input  t_in         i_data,
    output logic        o_stall,
    output logic        o_valid,
    output t_out        o_data,
    input  logic        i_stall,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    t_cfg       r_cfg;
    t_cmd       cmd;
    t_sts       sts;
    logic       cfg_wr;
    logic [2:0] cfg_idx;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign cfg_idx = paddr[4:2];

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.mass         <= 31'd65536;
            r_cfg.bounce       <= 17'd0;
            r_cfg.friction     <= 17'd0;
            r_cfg.time_step    <= 17'd1092;
            r_cfg.world_width  <= 31'd41943040;
            r_cfg.world_height <= 31'd31457280;
        end else if (cfg_wr) begin
            unique case (cfg_idx)
                REG_MASS:     r_cfg.mass         <= pwdata[30:0];
                REG_BOUNCE:   r_cfg.bounce       <= pwdata[16:0];
                REG_FRICTION: r_cfg.friction     <= pwdata[16:0];
                REG_TSTEP:    r_cfg.time_step    <= pwdata[16:0];
                REG_WIDTH:    r_cfg.world_width  <= pwdata[30:0];
                REG_HEIGHT:   r_cfg.world_height <= pwdata[30:0];
                default: ;
            endcase
        end
    end

    // register readback
    always_comb begin
        unique case (cfg_idx)
            REG_MASS:     prdata = 32'(r_cfg.mass);
            REG_BOUNCE:   prdata = 32'(r_cfg.bounce);
            REG_FRICTION: prdata = 32'(r_cfg.friction);
            REG_TSTEP:    prdata = 32'(r_cfg.time_step);
            REG_WIDTH:    prdata = 32'(r_cfg.world_width);
            REG_HEIGHT:   prdata = 32'(r_cfg.world_height);
            default:      prdata = '0;
        endcase
    end

    vpwb_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_valid),
        .i_op        (i_data.op),
        .i_out_stall (i_stall),
        .i_sts       (sts),
        .o_in_stall  (o_stall),
        .o_out_valid (o_valid),
        .o_cmd       (cmd)
    );

    vpwb_datapath u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_item  (i_data),
        .i_cmd   (cmd),
        .o_sts   (sts),
        .o_res   (o_data)
    );

endmodule

// File: dv/verlet_particle_with_wall_bounce_test.sv
`timescale 1ns / 1ps
module verlet_particle_with_wall_bounce_test;
    import vpwb_pkg::*;

    localparam int  WATCHDOG_LIMIT = 3000;
    localparam int  HOLD_CYCLES    = 400;
    localparam int  RANDOM_ITEMS   = 550;
    localparam int  MAX_REPORTS    = 10;
    localparam logic [2:0] OP_UNUSED = 3'd7;
    localparam logic [2:0] REG_SPARE = 3'd6;
    localparam longint Q_ONE  = 65536;
    localparam longint Q_MAXV = 64'sd2147483647;
    localparam longint Q_MINV = -64'sd2147483648;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    t_in         i_data = '0;
    logic        o_stall;
    logic        o_valid;
    t_out        o_data;
    logic        i_stall = 1'b0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [4:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    verlet_particle_with_wall_bounce dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .i_data(i_data), .o_stall(o_stall),
        .o_valid(o_valid), .o_data(o_data), .i_stall(i_stall),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    // clock
    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // particle state and registers as the block should hold them
    longint p_x, p_y, prev_x, prev_y, acc_x, acc_y;
    longint r_mass = 65536, r_bounce = 0, r_friction = 0, r_tstep = 1092;
    longint r_width = 41943040, r_height = 31457280;

    // pending positions, plus typed-in positions for some directed items
    t_out   pos_queue[$];
    bit     pin_has[$];
    t_out   pin_val[$];
    int     mismatches = 0;
    int     hold_req = 0;
    bit     idle_en = 1'b1;
    bit     stall_en = 1'b1;

    function automatic longint sat(longint v);
        if (v > Q_MAXV) return Q_MAXV;
        if (v < Q_MINV) return Q_MINV;
        return v;
    endfunction

    function automatic longint mag(longint v);
        return (v < 0) ? -v : v;
    endfunction

    // amount taken off the other axis after a wall hit
    function automatic longint wall_slide(longint j, longint k);
        if (j == 0) return 0;
        if (mag(j) <= mag(k)) return 2 * j;
        if ((k > 0 && j > 0) || (k < 0 && j < 0)) return k;
        return 0;
    endfunction

    function automatic t_out next_position(t_in it);
        longint vx, vy, dt2, nx, ny, dx, dy;
        t_out r;
        vx = it.vec_x;
        vy = it.vec_y;
        case (it.op)
            OP_ACCEL: begin
                acc_x = sat(acc_x + vx);
                acc_y = sat(acc_y + vy);
            end
            OP_FORCE: if (r_mass != 0) begin
                acc_x = sat(acc_x + (vx * Q_ONE) / r_mass);
                acc_y = sat(acc_y + (vy * Q_ONE) / r_mass);
            end
            OP_IMPULSE: if (r_mass != 0) begin
                p_x = sat(p_x + (vx * Q_ONE) / r_mass);
                p_y = sat(p_y + (vy * Q_ONE) / r_mass);
            end
            OP_RST_F: begin
                acc_x = 0;
                acc_y = 0;
            end
            OP_SIMULATE: if (r_mass != 0) begin
                dt2 = (r_tstep * r_tstep) >>> 16;
                nx = 2 * p_x - prev_x + ((acc_x * dt2) >>> 16);
                ny = 2 * p_y - prev_y + ((acc_y * dt2) >>> 16);
                prev_x = p_x;
                prev_y = p_y;
                p_x = sat(nx);
                p_y = sat(ny);
                acc_x = 0;
                acc_y = 0;
            end
            OP_RESTRAIN: begin
                // x walls
                if (p_x < 0 || p_x > r_width) begin
                    dx = p_x - prev_x;
                    dy = p_y - prev_y;
                    p_x = (p_x < 0) ? sat(-p_x) : sat(2 * r_width - p_x);
                    prev_x = sat(p_x + ((r_bounce * dx) >>> 16));
                    p_y = sat(p_y - wall_slide(dy, (dx * r_friction) >>> 16));
                end
                // y walls, on the updated values
                if (p_y < 0 || p_y > r_height) begin
                    dx = p_x - prev_x;
                    dy = p_y - prev_y;
                    p_y = (p_y < 0) ? sat(-p_y) : sat(2 * r_height - p_y);
                    prev_y = sat(p_y + ((r_bounce * dy) >>> 16));
                    p_x = sat(p_x - wall_slide(dx, (dy * r_friction) >>> 16));
                end
                // clamp into the box
                if (p_x < 0) p_x = 0;
                else if (p_x > r_width) p_x = r_width;
                if (p_y < 0) p_y = 0;
                else if (p_y > r_height) p_y = r_height;
            end
            OP_PLACE: begin
                p_x = vx;
                prev_x = vx;
                p_y = vy;
                prev_y = vy;
            end
            default: ;
        endcase
        r.pos_x = p_x[31:0];
        r.pos_y = p_y[31:0];
        return r;
    endfunction

    // input acceptance: predict, or take the typed-in position
    always @(posedge i_clk) begin
        t_out pred;
        if (i_rst_n && i_valid && !o_stall) begin
            pred = next_position(i_data);
            if (pin_has.pop_front()) pred = pin_val.pop_front();
            else void'(pin_val.pop_front());
            pos_queue.push_back(pred);
        end
    end

    // output acceptance and comparison
    always @(posedge i_clk) begin
        t_out want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (pos_queue.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("unexpected item: pos_x %h pos_y %h", o_data.pos_x, o_data.pos_y);
            end else begin
                want = pos_queue.pop_front();
                if (o_data.pos_x !== want.pos_x || o_data.pos_y !== want.pos_y) begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display("position mismatch: expected (%h, %h) got (%h, %h)",
                                 want.pos_x, want.pos_y, o_data.pos_x, o_data.pos_y);
                end
            end
        end
    end

    // receiver: random stall, plus a long hold-off on request
    always @(posedge i_clk) begin
        int hold_cnt;
        int hold_seen;
        if (!i_rst_n) begin
            i_stall <= 1'b0;
            hold_cnt = 0;
            hold_seen = 0;
        end else begin
            if (hold_req != hold_seen) begin
                hold_seen = hold_req;
                hold_cnt = HOLD_CYCLES;
            end
            if (hold_cnt > 0) begin
                hold_cnt--;
                i_stall <= 1'b1;
            end else begin
                i_stall <= stall_en && ($urandom_range(99) < 23);
            end
        end
    end

    // watchdog on cycles with no accepted input or output item
    always @(posedge i_clk) begin
        int quiet;
        if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall)) begin
            quiet = 0;
        end else begin
            quiet++;
            if (quiet >= WATCHDOG_LIMIT) begin
                $display("verlet_particle_with_wall_bounce_test failed");
                $finish;
            end
        end
    end

    task automatic reg_write(logic [2:0] idx, longint value);
        @(posedge i_clk);
        psel <= 1'b1;
        pwrite <= 1'b1;
        penable <= 1'b0;
        paddr <= {idx, 2'b00};
        pwdata <= value[31:0];
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            REG_MASS:     r_mass = value & 64'h7fffffff;
            REG_BOUNCE:   r_bounce = value & 64'h1ffff;
            REG_FRICTION: r_friction = value & 64'h1ffff;
            REG_TSTEP:    r_tstep = value & 64'h1ffff;
            REG_WIDTH:    r_width = value & 64'h7fffffff;
            REG_HEIGHT:   r_height = value & 64'h7fffffff;
            default: ;
        endcase
    endtask

    task automatic drain();
        while (pos_queue.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    task automatic send_item(t_in it, bit pinned, t_out pin);
        int gap;
        pin_has.push_back(pinned);
        pin_val.push_back(pin);
        i_valid <= 1'b1;
        i_data <= it;
        do @(posedge i_clk); while (o_stall);
        if (idle_en && $urandom_range(99) < 23) begin
            gap = $urandom_range(4, 1);
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    function automatic logic signed [31:0] pick_vec(longint span);
        int sel;
        sel = $urandom_range(99);
        if (sel < 50) return $signed($urandom_range(2621440)) - 32'sd1310720;
        if (sel < 75) return $urandom;
        return $signed($urandom_range(span[31:0] + 32'd2000000)) - 32'sd1000000;
    endfunction

    // mostly placement, forces, steps and wall checks with random content
    function automatic t_in pick_item();
        t_in it;
        int sel;
        sel = $urandom_range(99);
        if (sel < 10) it.op = OP_PLACE;
        else if (sel < 28) it.op = OP_ACCEL;
        else if (sel < 36) it.op = OP_FORCE;
        else if (sel < 44) it.op = OP_IMPULSE;
        else if (sel < 48) it.op = OP_RST_F;
        else if (sel < 70) it.op = OP_SIMULATE;
        else if (sel < 94) it.op = OP_RESTRAIN;
        else it.op = 3'($urandom_range(7));
        it.vec_x = pick_vec(r_width);
        it.vec_y = pick_vec(r_height);
        return it;
    endfunction

    typedef struct {
        logic [2:0]  op;
        logic [31:0] vx;
        logic [31:0] vy;
        bit          pinned;
        logic [31:0] ex;
        logic [31:0] ey;
    } t_row;

    t_row directed[] = '{
        '{OP_UNUSED,   32'h7fffffff, 32'h80000000, 1, 32'h0, 32'h0},
        '{OP_PLACE,    32'h7fffffff, 32'h80000000, 1, 32'h7fffffff, 32'h80000000},
        '{OP_ACCEL,    32'h7fffffff, 32'h7fffffff, 0, 32'h0, 32'h0},
        '{OP_ACCEL,    32'h7fffffff, 32'h80000000, 0, 32'h0, 32'h0},
        '{OP_SIMULATE, 32'h0,        32'h0,        0, 32'h0, 32'h0},
        '{OP_RESTRAIN, 32'h0,        32'h0,        0, 32'h0, 32'h0},
        '{OP_PLACE,    32'h80000000, 32'h7fffffff, 1, 32'h80000000, 32'h7fffffff},
        '{OP_IMPULSE,  32'h80000000, 32'h7fffffff, 0, 32'h0, 32'h0},
        '{OP_RESTRAIN, 32'h0,        32'h0,        0, 32'h0, 32'h0},
        '{OP_PLACE,    32'h00640000, 32'h00500000, 1, 32'h00640000, 32'h00500000},
        '{OP_FORCE,    32'h00030000, 32'hfffb0000, 0, 32'h0, 32'h0},
        '{OP_SIMULATE, 32'h0,        32'h0,        0, 32'h0, 32'h0},
        '{OP_ACCEL,    32'h10000000, 32'hf0000000, 0, 32'h0, 32'h0},
        '{OP_RST_F,    32'h0,        32'h0,        0, 32'h0, 32'h0},
        '{OP_SIMULATE, 32'h0,        32'h0,        0, 32'h0, 32'h0},
        '{OP_PLACE,    32'hfffb0000, 32'h00280000, 1, 32'hfffb0000, 32'h00280000},
        '{OP_IMPULSE,  32'hfff00000, 32'h00030000, 0, 32'h0, 32'h0},
        '{OP_RESTRAIN, 32'h0,        32'h0,        0, 32'h0, 32'h0},
        '{OP_PLACE,    32'h02bc0000, 32'hfffd0000, 1, 32'h02bc0000, 32'hfffd0000},
        '{OP_ACCEL,    32'h00200000, 32'hffe00000, 0, 32'h0, 32'h0},
        '{OP_SIMULATE, 32'h0,        32'h0,        0, 32'h0, 32'h0},
        '{OP_RESTRAIN, 32'h0,        32'h0,        0, 32'h0, 32'h0},
        '{OP_UNUSED,   32'h12345678, 32'hedcba987, 0, 32'h0, 32'h0}
    };

    initial begin
        t_in  it;
        t_out pin;
        int   phase;
        int   n;
        p_x = 0; p_y = 0; prev_x = 0; prev_y = 0; acc_x = 0; acc_y = 0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed table with reset settings
        foreach (directed[i]) begin
            it.op = directed[i].op;
            it.vec_x = directed[i].vx;
            it.vec_y = directed[i].vy;
            pin.pos_x = directed[i].ex;
            pin.pos_y = directed[i].ey;
            send_item(it, directed[i].pinned, pin);
        end
        i_valid <= 1'b0;
        drain();

        // random phases, each under its own register setting
        for (phase = 0; phase < 7; phase++) begin
            case (phase)
                0: begin
                    reg_write(REG_BOUNCE, 65536);
                    reg_write(REG_FRICTION, 65536);
                    hold_req++;
                end
                1: begin
                    reg_write(REG_MASS, 0);
                    idle_en = 1'b0;
                    stall_en = 1'b0;
                end
                2: begin
                    reg_write(REG_MASS, 64'h7fffffff);
                    reg_write(REG_TSTEP, 64'h1ffff);
                    reg_write(REG_BOUNCE, 64'h1ffff);
                    reg_write(REG_FRICTION, 64'h1ffff);
                    idle_en = 1'b1;
                    stall_en = 1'b1;
                end
                3: begin
                    reg_write(REG_WIDTH, 0);
                    reg_write(REG_HEIGHT, 0);
                    reg_write(REG_TSTEP, 0);
                    reg_write(REG_MASS, 1);
                end
                4: begin
                    reg_write(REG_WIDTH, 64'h7fffffff);
                    reg_write(REG_HEIGHT, 64'h7fffffff);
                    reg_write(REG_SPARE, 64'h0);
                    reg_write(REG_MASS, 65536);
                end
                default: begin
                    reg_write(REG_MASS, $urandom_range(32'h7fffffff, 1));
                    reg_write(REG_BOUNCE, $urandom_range(65536));
                    reg_write(REG_FRICTION, $urandom_range(65536));
                    reg_write(REG_TSTEP, $urandom_range(65536));
                    reg_write(REG_WIDTH, $urandom_range(32'h7fffffff));
                    reg_write(REG_HEIGHT, $urandom_range(32'h7fffffff));
                end
            endcase
            for (n = 0; n < RANDOM_ITEMS / 7; n++) begin
                it = pick_item();
                send_item(it, 1'b0, pin);
                // sender pause until every position is back
                if (phase == 5 && n == 30) begin
                    i_valid <= 1'b0;
                    while (pos_queue.size() != 0) @(posedge i_clk);
                end
            end
            i_valid <= 1'b0;
            drain();
        end

        if (mismatches == 0) begin
            $display("verlet_particle_with_wall_bounce_test passed");
        end else begin
            $display("verlet_particle_with_wall_bounce_test failed");
        end
        $finish;
    end

endmodule
